// ===== rtl/structured_value_unescape_splitter_macros.svh =====
// assertion helpers shared by the checker
`ifndef STRUCTURED_VALUE_UNESCAPE_SPLITTER_MACROS_SVH
`define STRUCTURED_VALUE_UNESCAPE_SPLITTER_MACROS_SVH

// same-cycle implication, quiet while reset is asserted
`define SVUS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("svus check failed");

// next-cycle implication, quiet while reset is asserted
`define SVUS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("svus check failed");

`endif

// ===== rtl/svus_pkg.sv =====
package svus_pkg;

	localparam int MAX_LIMIT_DEF   = 255;
	localparam int QUEUE_DEPTH_DEF = 4;

	// most results one item can cause
	localparam int MAX_RES = 5;
	localparam int RCW     = $clog2(MAX_RES + 1);
	localparam int RIW     = $clog2(MAX_RES);

	typedef enum logic [1:0] {
		KIND_DATA   = 2'd0,
		KIND_VALUE  = 2'd1,
		KIND_COMP   = 2'd2,
		KIND_STRING = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		MODE_STRUCT = 2'd0,
		MODE_COMMA  = 2'd1,
		MODE_SEMI   = 2'd2
	} mode_t;

	localparam logic REG_SPLIT_MODE  = 1'b0;
	localparam logic REG_SPLIT_LIMIT = 1'b1;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_UP_N   = 8'h4E;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} res_t;

	// all results caused by one item, first in slot 0
	typedef struct packed {
		logic [RCW-1:0]            cnt;
		res_t [MAX_RES-1:0]        res;
	} cmd_t;

endpackage

// ===== rtl/svus_front.sv =====
module svus_front #(
	parameter int MAX_LIMIT = svus_pkg::MAX_LIMIT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [7:0]        cfg_data,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [7:0]        s_tdata,
	input  logic              s_tlast,
	input  logic              s_tuser,
	output logic              push,
	output svus_pkg::cmd_t    cmd
);
	import svus_pkg::*;

	localparam int PCW = $clog2(MAX_LIMIT + 1);
	localparam int CW  = ((PCW > 8) ? PCW : 8) + 1;

	logic [1:0]     mode_q;
	logic [7:0]     limit_q;
	logic           esc_q, vn_q, chv_q, frz_q;
	logic [PCW-1:0] pc_q;
	logic           esc_d, vn_d, chv_d, frz_d;
	logic [PCW-1:0] pc_d;
	logic           accept;

	assign accept = s_tvalid && s_tready;

	always_comb begin
		logic [RCW-1:0] n;
		logic [CW-1:0]  pc_inc;
		logic           frz;
		esc_d  = esc_q;
		vn_d   = vn_q;
		chv_d  = chv_q;
		frz_d  = frz_q;
		pc_d   = pc_q;
		cmd    = '0;
		n      = '0;
		frz    = frz_q;
		pc_inc = CW'(pc_q) + CW'(1);
		if (s_tuser) begin
			esc_d = 1'b0;
			vn_d  = 1'b0;
			chv_d = 1'b0;
			frz_d = 1'b0;
			pc_d  = '0;
			cmd.res[0] = '{kind: KIND_STRING, data: 8'h00};
			n = RCW'(1);
		end else begin
			if (esc_q) begin
				esc_d = 1'b0;
				vn_d  = 1'b1;
				if (s_tdata == CH_LOW_N || s_tdata == CH_UP_N) begin
					cmd.res[n] = '{kind: KIND_DATA, data: CH_CR};
					n = n + RCW'(1);
					cmd.res[n] = '{kind: KIND_DATA, data: CH_LF};
					n = n + RCW'(1);
				end else begin
					cmd.res[n] = '{kind: KIND_DATA, data: s_tdata};
					n = n + RCW'(1);
				end
			end else if (s_tdata == CH_BSLASH) begin
				// a lone backslash at the end is plain data
				if (s_tlast) begin
					cmd.res[n] = '{kind: KIND_DATA, data: s_tdata};
					n = n + RCW'(1);
					vn_d = 1'b1;
				end else begin
					esc_d = 1'b1;
				end
			end else begin
				case (mode_q)
					MODE_STRUCT: begin
						if (s_tdata == CH_SEMI) begin
							if (chv_q || vn_q) begin
								cmd.res[n] = '{kind: KIND_VALUE, data: 8'h00};
								n = n + RCW'(1);
							end
							cmd.res[n] = '{kind: KIND_COMP, data: 8'h00};
							n = n + RCW'(1);
							chv_d = 1'b0;
							vn_d  = 1'b0;
						end else if (s_tdata == CH_COMMA) begin
							cmd.res[n] = '{kind: KIND_VALUE, data: 8'h00};
							n = n + RCW'(1);
							vn_d  = 1'b0;
							chv_d = 1'b1;
						end else begin
							cmd.res[n] = '{kind: KIND_DATA, data: s_tdata};
							n = n + RCW'(1);
							vn_d = 1'b1;
						end
					end
					MODE_COMMA: begin
						if (s_tdata == CH_COMMA) begin
							cmd.res[n] = '{kind: KIND_VALUE, data: 8'h00};
							n = n + RCW'(1);
							vn_d = 1'b0;
						end else begin
							cmd.res[n] = '{kind: KIND_DATA, data: s_tdata};
							n = n + RCW'(1);
							vn_d = 1'b1;
						end
					end
					default: begin
						// semicolon list; the unused mode code acts the same
						if (s_tdata == CH_SEMI) begin
							frz = frz_q || (limit_q != 8'h00 && CW'(limit_q) <= pc_inc);
							frz_d = frz;
						end
						if (s_tdata == CH_SEMI && !frz) begin
							cmd.res[n] = '{kind: KIND_VALUE, data: 8'h00};
							n = n + RCW'(1);
							vn_d = 1'b0;
							if (pc_q < PCW'(MAX_LIMIT))
								pc_d = pc_inc[PCW-1:0];
						end else begin
							cmd.res[n] = '{kind: KIND_DATA, data: s_tdata};
							n = n + RCW'(1);
							vn_d = 1'b1;
						end
					end
				endcase
			end
			if (s_tlast) begin
				if (mode_q == MODE_STRUCT) begin
					// trailing empty component is dropped
					if (chv_d || vn_d) begin
						cmd.res[n] = '{kind: KIND_VALUE, data: 8'h00};
						n = n + RCW'(1);
						cmd.res[n] = '{kind: KIND_COMP, data: 8'h00};
						n = n + RCW'(1);
					end
				end else begin
					cmd.res[n] = '{kind: KIND_VALUE, data: 8'h00};
					n = n + RCW'(1);
				end
				cmd.res[n] = '{kind: KIND_STRING, data: 8'h00};
				n = n + RCW'(1);
				esc_d = 1'b0;
				vn_d  = 1'b0;
				chv_d = 1'b0;
				frz_d = 1'b0;
				pc_d  = '0;
			end
		end
		cmd.cnt = n;
	end

	assign push = accept && (cmd.cnt != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_STRUCT;
			limit_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPLIT_MODE:  mode_q  <= cfg_data[1:0];
				REG_SPLIT_LIMIT: limit_q <= cfg_data;
				default:         ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= 1'b0;
			vn_q  <= 1'b0;
			chv_q <= 1'b0;
			frz_q <= 1'b0;
			pc_q  <= '0;
		end else if (accept) begin
			esc_q <= esc_d;
			vn_q  <= vn_d;
			chv_q <= chv_d;
			frz_q <= frz_d;
			pc_q  <= pc_d;
		end
	end

endmodule

// ===== rtl/svus_queue.sv =====
module svus_queue #(
	parameter int DEPTH = svus_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  svus_pkg::cmd_t wr_cmd,
	output logic           full,
	input  logic           pop,
	output logic           rd_valid,
	output svus_pkg::cmd_t rd_cmd
);
	import svus_pkg::*;

	localparam int CNTW = $clog2(DEPTH + 1);

	cmd_t           ent_q [DEPTH];
	logic [CNTW-1:0] count_q;
	logic [CNTW-1:0] wr_pos;

	assign full     = (count_q == CNTW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_cmd   = ent_q[0];
	// head sits in slot 0, so the write slot moves down on a pop
	assign wr_pos   = pop ? count_q - CNTW'(1) : count_q;

	// each slot takes either the new list or its upper neighbor
	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH - 1; i++) begin
			if (push && wr_pos == CNTW'(i))
				ent_q[i] <= wr_cmd;
			else if (pop)
				ent_q[i] <= ent_q[i + 1];
		end
		if (push && wr_pos == CNTW'(DEPTH - 1))
			ent_q[DEPTH - 1] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case ({push, pop})
				2'b10:   count_q <= count_q + CNTW'(1);
				2'b01:   count_q <= count_q - CNTW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/svus_back.sv =====
module svus_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  svus_pkg::cmd_t q_cmd,
	output logic           pop,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [7:0]     m_tdata,
	output logic           m_tlast,
	output logic [1:0]     m_tuser
);
	import svus_pkg::*;

	cmd_t           cmd_q;
	logic           valid_q;
	logic [RIW-1:0] idx_q;
	res_t           cur;
	logic           last;

	assign cur  = cmd_q.res[idx_q];
	assign last = (RCW'(idx_q) == cmd_q.cnt - RCW'(1));
	assign pop  = q_valid && (!valid_q || (m_tready && last));

	assign m_tvalid = valid_q;
	assign m_tdata  = cur.data;
	assign m_tuser  = cur.kind;
	assign m_tlast  = last;

	always_ff @(posedge clk) begin
		if (pop)
			cmd_q <= q_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (pop) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (valid_q && m_tready) begin
			if (last)
				valid_q <= 1'b0;
			else
				idx_q <= idx_q + RIW'(1);
		end
	end

endmodule

// ===== rtl/structured_value_unescape_splitter.sv =====
// an item accepted with nothing queued ahead goes into a queue slot, then into the
// back's output register, from which its first result shows
// throughput: one item per cycle with m_tready high and at most one result per item
// output port moves one result per cycle with m_tready high, each item's results in a row
// items that only open an escape cause no result and take no queue slot
// reset (arst_n low, asynchronous): queue and output emptied, parse state and
// both config registers cleared to zero
module structured_value_unescape_splitter #(
	parameter int MAX_LIMIT   = svus_pkg::MAX_LIMIT_DEF,
	parameter int QUEUE_DEPTH = svus_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	// config write port: index 0 split_mode, index 1 split_limit
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	// input stream
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,   // is_last
	input  logic       s_tuser,   // [0] is_empty
	// result stream
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast,   // run_last
	output logic [1:0] m_tuser    // [1:0] out_kind
);
	import svus_pkg::*;

	logic full;
	logic push;
	logic pop;
	logic q_valid;
	cmd_t f_cmd;
	cmd_t q_cmd;

	// front takes a byte whenever the queue has a free slot
	assign s_tready = !full;

	// front: config registers, escape and split state, builds the result list
	svus_front #(
		.MAX_LIMIT (MAX_LIMIT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.push      (push),
		.cmd       (f_cmd)
	);

	// short queue of result lists decouples input from output stalls
	svus_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_cmd   (f_cmd),
		.full     (full),
		.pop      (pop),
		.rd_valid (q_valid),
		.rd_cmd   (q_cmd)
	);

	// back: holds one list and hands out its results one per cycle while m_tready is high
	svus_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== rtl/svus_checker.sv =====
`include "structured_value_unescape_splitter_macros.svh"

module svus_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic [1:0] m_tuser
);
	import svus_pkg::*;

	`SVUS_ASSERT_NEXT(a_hold_valid, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`SVUS_ASSERT_NEXT(a_hold_data, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
	// end of string always closes the run of one item
	`SVUS_ASSERT_NOW(a_string_last, clk, arst_n, m_tvalid && m_tuser == KIND_STRING, m_tlast)
	// boundary markers carry no byte
	`SVUS_ASSERT_NOW(a_marker_zero, clk, arst_n, m_tvalid && m_tuser != KIND_DATA, m_tdata == 8'h00)

endmodule

bind structured_value_unescape_splitter svus_checker u_svus_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
